@@ src/hpsr_pkg.sv @@
package hpsr_pkg;

   localparam int BYTE_W = 8;
   localparam int TYPE_W = 5;

   // two bits of history per byte: unseen, zero, other, one
   localparam logic [1:0] HIST_ZERO  = 2'd1;
   localparam logic [1:0] HIST_OTHER = 2'd2;
   localparam logic [1:0] HIST_ONE   = 2'd3;

   // history of 00 00 00 01: the current byte is a NAL header
   localparam logic [BYTE_W-1:0] START_CODE_HIST = 8'h57;

   localparam logic [TYPE_W-1:0] NAL_IDR = 5'd5;
   localparam logic [TYPE_W-1:0] NAL_SPS = 5'd7;
   localparam logic [TYPE_W-1:0] NAL_PPS = 5'd8;

   typedef struct packed {
      logic is_hdr;
      logic is_sps;
      logic is_pps;
      logic is_idr;
   } hdr_info_type;

endpackage

@@ src/hpsr_store.sv @@
module hpsr_store #(
   parameter int STORE_DEPTH = 31
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(STORE_DEPTH)-1:0]    wr_addr,
   input  logic [hpsr_pkg::BYTE_W-1:0]       wr_data,
   input  logic [$clog2(STORE_DEPTH)-1:0]    rd_addr,
   output logic [hpsr_pkg::BYTE_W-1:0]       rd_data
);

   logic [hpsr_pkg::BYTE_W-1:0] store_ff [STORE_DEPTH];
   logic [hpsr_pkg::BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/hpsr_detect.sv @@
module hpsr_detect (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [hpsr_pkg::BYTE_W-1:0]   stream_byte,
   output hpsr_pkg::hdr_info_type        hdr_info
);

   logic [hpsr_pkg::BYTE_W-1:0] history_ff;
   logic [hpsr_pkg::BYTE_W-1:0] history_in;
   logic [1:0]                  code;
   logic [hpsr_pkg::TYPE_W-1:0] nal_type;

   assign nal_type = stream_byte[hpsr_pkg::TYPE_W-1:0];

   always_comb begin
      priority if (stream_byte == 8'h00) begin
         code = hpsr_pkg::HIST_ZERO;
      end else if (stream_byte == 8'h01) begin
         code = hpsr_pkg::HIST_ONE;
      end else begin
         code = hpsr_pkg::HIST_OTHER;
      end
      history_in = accept ? {history_ff[hpsr_pkg::BYTE_W-3:0], code} : history_ff;
   end

   always_comb begin
      hdr_info.is_hdr = (history_ff == hpsr_pkg::START_CODE_HIST);
      hdr_info.is_sps = hdr_info.is_hdr && (nal_type == hpsr_pkg::NAL_SPS);
      hdr_info.is_pps = hdr_info.is_hdr && (nal_type == hpsr_pkg::NAL_PPS);
      hdr_info.is_idr = hdr_info.is_hdr && (nal_type == hpsr_pkg::NAL_IDR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         history_ff <= '0;
      end else begin
         history_ff <= history_in;
      end
   end

endmodule

@@ src/h264_param_set_reinserter_core.sv @@
// Channel   Ports                                               Direction  Item
// req       req_valid, req_stall, req_stream_byte               in         one stream byte
// rsp       rsp_valid, rsp_stall, rsp_out_byte, rsp_run_last    out        one output byte
//
// A passed byte is registered in the output register; bytes stream at one per cycle while
// nothing is injected and rsp is not stalled. An IDR header with stored parameter sets is
// held while the stored bytes leave both stores through their read ports, SPS then PPS,
// one per cycle unless rsp stalls; the header goes last. Reset (synchronous, active high)
// empties both stores and clears the start-code history. A stall on rsp holds the output
// register and stalls req; req is also stalled while a run of stored bytes is being sent.
module h264_param_set_reinserter_core #(
   parameter int STORE_DEPTH = 31
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [hpsr_pkg::BYTE_W-1:0]   req_stream_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [hpsr_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_run_last
);

   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int LEN_W = $clog2(STORE_DEPTH + 1);

   typedef enum logic [1:0] {
      S_PASS,   // taking stream bytes
      S_SPS,    // sending stored SPS bytes
      S_PPS,    // sending stored PPS bytes
      S_LAST    // sending the held IDR header byte
   } state_type;

   typedef enum logic [1:0] {
      T_NONE,
      T_SPS,
      T_PPS
   } target_type;

   state_type                   state_ff, state_in;
   target_type                  target_ff, target_in;
   logic [LEN_W-1:0]            sps_len_ff, sps_len_in;
   logic [LEN_W-1:0]            pps_len_ff, pps_len_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic [hpsr_pkg::BYTE_W-1:0] hold_ff, hold_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [hpsr_pkg::BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic                        accept;
   logic                        slot_free;
   hpsr_pkg::hdr_info_type      hdr_info;
   logic                        sps_we, pps_we;
   logic [IDX_W-1:0]            sps_waddr, pps_waddr;
   logic [hpsr_pkg::BYTE_W-1:0] sps_rdata, pps_rdata;
   logic                        sps_idx_last, pps_idx_last;

   // output register is free when empty or being taken this cycle
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_PASS) || !slot_free;
   assign accept    = req_valid && !req_stall;

   hpsr_detect u_detect (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stream_byte (req_stream_byte),
      .hdr_info    (hdr_info)
   );

   // both stores are read at the next index, so read data matches idx_ff
   hpsr_store #(.STORE_DEPTH(STORE_DEPTH)) u_sps_store (
      .clock   (clock),
      .wr_en   (sps_we),
      .wr_addr (sps_waddr),
      .wr_data (req_stream_byte),
      .rd_addr (idx_in),
      .rd_data (sps_rdata)
   );

   hpsr_store #(.STORE_DEPTH(STORE_DEPTH)) u_pps_store (
      .clock   (clock),
      .wr_en   (pps_we),
      .wr_addr (pps_waddr),
      .wr_data (req_stream_byte),
      .rd_addr (idx_in),
      .rd_data (pps_rdata)
   );

   assign sps_idx_last = (LEN_W'(idx_ff) + LEN_W'(1)) == sps_len_ff;
   assign pps_idx_last = (LEN_W'(idx_ff) + LEN_W'(1)) == pps_len_ff;

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      sps_len_in   = sps_len_ff;
      pps_len_in   = pps_len_ff;
      idx_in       = idx_ff;
      hold_in      = hold_ff;
      rsp_valid_in = rsp_stall ? rsp_valid_ff : 1'b0;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      sps_we       = 1'b0;
      pps_we       = 1'b0;
      sps_waddr    = '0;
      pps_waddr    = '0;

      unique case (state_ff)
         S_PASS: begin
            idx_in = '0;
            if (accept) begin
               // header byte decides the recording target
               if (hdr_info.is_sps) begin
                  target_in  = T_SPS;
                  sps_len_in = '0;
               end else if (hdr_info.is_pps) begin
                  target_in  = T_PPS;
                  pps_len_in = '0;
               end else if (hdr_info.is_hdr) begin
                  target_in = T_NONE;
               end

               // record, or drop the store on overflow
               if (target_in == T_SPS) begin
                  if (sps_len_in == LEN_W'(STORE_DEPTH)) begin
                     sps_len_in = '0;
                     target_in  = T_NONE;
                  end else begin
                     sps_we     = 1'b1;
                     sps_waddr  = sps_len_in[IDX_W-1:0];
                     sps_len_in = sps_len_in + LEN_W'(1);
                  end
               end else if (target_in == T_PPS) begin
                  if (pps_len_in == LEN_W'(STORE_DEPTH)) begin
                     pps_len_in = '0;
                     target_in  = T_NONE;
                  end else begin
                     pps_we     = 1'b1;
                     pps_waddr  = pps_len_in[IDX_W-1:0];
                     pps_len_in = pps_len_in + LEN_W'(1);
                  end
               end

               // IDR while idle: hold the header, send stored sets first
               if (hdr_info.is_idr && (target_ff == T_NONE) &&
                   ((sps_len_ff != '0) || (pps_len_ff != '0))) begin
                  hold_in  = req_stream_byte;
                  state_in = (sps_len_ff != '0) ? S_SPS : S_PPS;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_byte_in  = req_stream_byte;
                  rsp_last_in  = 1'b1;
               end
            end
         end
         S_SPS: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = sps_rdata;
               rsp_last_in  = 1'b0;
               if (sps_idx_last) begin
                  idx_in   = '0;
                  state_in = (pps_len_ff != '0) ? S_PPS : S_LAST;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         S_PPS: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = pps_rdata;
               rsp_last_in  = 1'b0;
               if (pps_idx_last) begin
                  idx_in   = '0;
                  state_in = S_LAST;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         S_LAST: begin
            idx_in = '0;
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = hold_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_PASS;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_PASS;
         target_ff    <= T_NONE;
         sps_len_ff   <= '0;
         pps_len_ff   <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         sps_len_ff   <= sps_len_in;
         pps_len_ff   <= pps_len_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hold_ff     <= hold_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_run_last = rsp_last_ff;

   // store lengths never pass the store depth
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (sps_len_ff <= LEN_W'(STORE_DEPTH)) && (pps_len_ff <= LEN_W'(STORE_DEPTH)))
      else $error("store length beyond depth");

   // injection only starts with no recording active
   a_inject_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_PASS) |-> (target_ff == T_NONE))
      else $error("injection while recording");

   // a stored byte on the output means its run is still open
   a_run_open: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (state_ff != S_PASS))
      else $error("injected byte without a closing item");

   // starting a run never loads the output register
   a_run_start: assert property (@(posedge clock) disable iff (reset)
      ($past(state_ff) == S_PASS && state_ff != S_PASS && $past(rsp_stall)) |->
      !rsp_valid_ff || $stable(rsp_byte_ff))
      else $error("output changed on run start");

endmodule
